// ===== design/i2crts_pkg.sv =====
`timescale 1ns / 1ps

package i2crts_pkg;

    // Input opcodes.
    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_STATUS  = 3'd1;
    localparam logic [2:0] OP_RX_DONE = 3'd2;
    localparam logic [2:0] OP_TX_DONE = 3'd3;
    localparam logic [2:0] OP_TIMEOUT = 3'd4;

    // Phases of one register transfer. Codes nine and up are never reached.
    typedef enum logic [3:0] {
        PH_IDLE         = 4'd0,
        PH_ADDRESS      = 4'd1,
        PH_REGISTER     = 4'd2,
        PH_READ         = 4'd3,
        PH_READ_ADDRESS = 4'd4,
        PH_READ_DATA    = 4'd5,
        PH_DATA         = 4'd6,
        PH_DMA_WAIT     = 4'd7,
        PH_BYTE_WAIT    = 4'd8
    } phase_t;

    // Bus status events, in order of priority.
    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_START_SENT    = 3'd1,
        EV_HEADER10      = 3'd2,
        EV_TX_ADDRESSED  = 3'd3,
        EV_RX_ADDRESSED  = 3'd4,
        EV_BYTE_FINISHED = 3'd5,
        EV_TX_EMPTY      = 3'd6
    } event_t;

    // Bus status bits of one status word.
    typedef struct packed {
        logic start_sent;
        logic header10;
        logic tx_empty;
        logic addressed;
        logic byte_finished;
        logic bus_busy;
        logic master;
        logic transmitter;
    } status_t;

    // Action flags of one result word.
    typedef struct packed {
        logic       peripheral_on;
        logic       peripheral_off;
        logic       send_start;
        logic       send_stop;
        logic       send_address;
        logic [6:0] address_out;
        logic       address_read;
        logic       send_data;
        logic [7:0] data_out;
        logic       dma_on;
        logic       dma_off;
        logic       done_res;
    } result_t;

endpackage

// ===== design/i2crts_classify.sv =====
`timescale 1ns / 1ps

// Reduces the status bits of a status word to a single event by fixed priority; any other word yields no event.
module i2crts_classify
(
    input  logic [2:0]                opcode,
    input  i2crts_pkg::status_t       status,
    output i2crts_pkg::event_t        bus_event
);

    logic bm;

    assign bm = status.bus_busy & status.master;

    always_comb
    begin
        if (opcode != i2crts_pkg::OP_STATUS)
        begin
            bus_event = i2crts_pkg::EV_NONE;
        end
        else
        begin
            priority if (status.start_sent && bm)
            begin
                bus_event = i2crts_pkg::EV_START_SENT;
            end
            else if (status.header10 && bm)
            begin
                bus_event = i2crts_pkg::EV_HEADER10;
            end
            else if (status.tx_empty && status.addressed && bm && status.transmitter)
            begin
                bus_event = i2crts_pkg::EV_TX_ADDRESSED;
            end
            else if (status.addressed && bm)
            begin
                bus_event = i2crts_pkg::EV_RX_ADDRESSED;
            end
            else if (status.byte_finished)
            begin
                bus_event = i2crts_pkg::EV_BYTE_FINISHED;
            end
            else if (status.tx_empty)
            begin
                bus_event = i2crts_pkg::EV_TX_EMPTY;
            end
            else
            begin
                bus_event = i2crts_pkg::EV_NONE;
            end
        end
    end

endmodule

// ===== design/i2crts_fsm.sv =====
`timescale 1ns / 1ps

// Transfer phase walk. The phase and the latched transfer target change only
// on an accepted word; the result for that word is formed combinationally.
module i2crts_fsm
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [2:0]                opcode,
    input  logic                      read_not_write,
    input  logic [7:0]                device_address,
    input  logic [7:0]                register_address,
    input  i2crts_pkg::event_t        bus_event,
    output i2crts_pkg::result_t       result
);

    i2crts_pkg::phase_t phase_reg;
    i2crts_pkg::phase_t phase_next;
    logic               direction_read_reg;
    logic [6:0]         target_address_reg;
    logic [7:0]         target_register_reg;
    logic               latch_start;

    assign latch_start = accept && (phase_reg == i2crts_pkg::PH_IDLE)
                         && (opcode == i2crts_pkg::OP_START);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            i2crts_pkg::PH_IDLE:
            begin
                if (opcode == i2crts_pkg::OP_START)
                    phase_next = i2crts_pkg::PH_ADDRESS;
            end
            i2crts_pkg::PH_ADDRESS:
            begin
                if (bus_event == i2crts_pkg::EV_START_SENT)
                    phase_next = i2crts_pkg::PH_REGISTER;
            end
            i2crts_pkg::PH_REGISTER:
            begin
                if (bus_event == i2crts_pkg::EV_TX_ADDRESSED)
                    phase_next = direction_read_reg ? i2crts_pkg::PH_READ
                                                    : i2crts_pkg::PH_DATA;
            end
            i2crts_pkg::PH_READ:
            begin
                if (bus_event == i2crts_pkg::EV_TX_EMPTY)
                    phase_next = i2crts_pkg::PH_READ_ADDRESS;
            end
            i2crts_pkg::PH_READ_ADDRESS:
            begin
                if (bus_event == i2crts_pkg::EV_START_SENT)
                    phase_next = i2crts_pkg::PH_READ_DATA;
            end
            i2crts_pkg::PH_READ_DATA:
            begin
                if (bus_event == i2crts_pkg::EV_RX_ADDRESSED)
                    phase_next = i2crts_pkg::PH_DMA_WAIT;
            end
            i2crts_pkg::PH_DATA:
            begin
                if (bus_event == i2crts_pkg::EV_TX_EMPTY)
                    phase_next = i2crts_pkg::PH_DMA_WAIT;
            end
            i2crts_pkg::PH_DMA_WAIT:
            begin
                if (opcode == i2crts_pkg::OP_RX_DONE)
                    phase_next = i2crts_pkg::PH_IDLE;
                else if (opcode == i2crts_pkg::OP_TX_DONE)
                    phase_next = i2crts_pkg::PH_BYTE_WAIT;
            end
            i2crts_pkg::PH_BYTE_WAIT:
            begin
                if (bus_event == i2crts_pkg::EV_BYTE_FINISHED)
                    phase_next = i2crts_pkg::PH_IDLE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Action flags for the current word.
    always_comb
    begin
        result = '0;
        unique case (phase_reg)
            i2crts_pkg::PH_IDLE:
            begin
                if (opcode == i2crts_pkg::OP_START)
                begin
                    result.peripheral_on = 1'b1;
                    result.send_start    = 1'b1;
                end
            end
            i2crts_pkg::PH_ADDRESS:
            begin
                if (bus_event == i2crts_pkg::EV_START_SENT)
                begin
                    result.send_address = 1'b1;
                    result.address_out  = target_address_reg;
                end
            end
            i2crts_pkg::PH_REGISTER:
            begin
                if (bus_event == i2crts_pkg::EV_TX_ADDRESSED)
                begin
                    result.send_data = 1'b1;
                    result.data_out  = target_register_reg;
                end
            end
            i2crts_pkg::PH_READ:
            begin
                if (bus_event == i2crts_pkg::EV_TX_EMPTY)
                    result.send_start = 1'b1;
            end
            i2crts_pkg::PH_READ_ADDRESS:
            begin
                if (bus_event == i2crts_pkg::EV_START_SENT)
                begin
                    result.send_address = 1'b1;
                    result.address_out  = target_address_reg;
                    result.address_read = 1'b1;
                end
            end
            i2crts_pkg::PH_READ_DATA:
            begin
                if (bus_event == i2crts_pkg::EV_RX_ADDRESSED)
                    result.dma_on = 1'b1;
            end
            i2crts_pkg::PH_DATA:
            begin
                if (bus_event == i2crts_pkg::EV_TX_EMPTY)
                    result.dma_on = 1'b1;
            end
            i2crts_pkg::PH_DMA_WAIT:
            begin
                if (opcode == i2crts_pkg::OP_RX_DONE)
                begin
                    result.dma_off        = 1'b1;
                    result.send_stop      = 1'b1;
                    result.peripheral_off = 1'b1;
                    result.done_res       = 1'b1;
                end
                else if (opcode == i2crts_pkg::OP_TX_DONE)
                begin
                    result.dma_off = 1'b1;
                end
            end
            i2crts_pkg::PH_BYTE_WAIT:
            begin
                if (bus_event == i2crts_pkg::EV_BYTE_FINISHED)
                begin
                    result.send_stop      = 1'b1;
                    result.peripheral_off = 1'b1;
                    result.done_res       = 1'b1;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= i2crts_pkg::PH_IDLE;
            direction_read_reg  <= 1'b0;
            target_address_reg  <= '0;
            target_register_reg <= '0;
        end
        else
        begin
            if (accept)
                phase_reg <= phase_next;
            if (latch_start)
            begin
                direction_read_reg  <= read_not_write;
                target_address_reg  <= device_address[7:1];
                target_register_reg <= register_address;
            end
        end
    end

endmodule

// ===== design/i2c_register_transfer_sequencer_top.sv =====
`timescale 1ns / 1ps

// I2C master register transfer sequencer.
// The input channel (in_valid / in_stall) carries one word per step: a start
// word with direction, device address and register byte, a bus status word,
// a DMA done word or a timeout. The output channel (out_valid / out_stall)
// returns exactly one word of action flags for every accepted input word; a
// word that does not fit the current phase yields all-zero flags.
// The flags for an accepted word are registered and shown from the next cycle
// on. Throughput is one word per cycle while the receiver does not stall, set
// by the single output register, which is loaded in the same edge as the phase.
// When the receiver stalls, the output register holds its word and in_stall
// rises only while that register is full and stalled; as soon as the word is
// taken, a new input word can be accepted in the same cycle.
// Reset clears the phase to idle, the latched transfer target to zero and
// the output valid; no word is shown until the first word is accepted.
module i2c_register_transfer_sequencer_top
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] opcode,
    input  logic       read_not_write,
    input  logic [7:0] device_address,
    input  logic [7:0] register_address,
    input  logic       flag_start_sent,
    input  logic       flag_header10,
    input  logic       flag_tx_empty,
    input  logic       flag_addressed,
    input  logic       flag_byte_finished,
    input  logic       flag_bus_busy,
    input  logic       flag_master,
    input  logic       flag_transmitter,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       peripheral_on,
    output logic       peripheral_off,
    output logic       send_start,
    output logic       send_stop,
    output logic       send_address,
    output logic [6:0] address_out,
    output logic       address_read,
    output logic       send_data,
    output logic [7:0] data_out,
    output logic       dma_on,
    output logic       dma_off,
    output logic       done_res
);

    i2crts_pkg::status_t status;
    i2crts_pkg::event_t  bus_event;
    i2crts_pkg::result_t result;
    i2crts_pkg::result_t result_reg;
    logic                out_valid_reg;
    logic                accept;

    // The input waits only while a finished word sits unclaimed in the output.
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign status.start_sent    = flag_start_sent;
    assign status.header10      = flag_header10;
    assign status.tx_empty      = flag_tx_empty;
    assign status.addressed     = flag_addressed;
    assign status.byte_finished = flag_byte_finished;
    assign status.bus_busy      = flag_bus_busy;
    assign status.master        = flag_master;
    assign status.transmitter   = flag_transmitter;

    i2crts_classify u_classify
    (
        .opcode    (opcode),
        .status    (status),
        .bus_event (bus_event)
    );

    i2crts_fsm u_fsm
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .opcode           (opcode),
        .read_not_write   (read_not_write),
        .device_address   (device_address),
        .register_address (register_address),
        .bus_event        (bus_event),
        .result           (result)
    );

    // Output valid: set by an accepted word, cleared once the word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload needs no reset; it is loaded only with an accepted word.
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result;
    end

    assign out_valid      = out_valid_reg;
    assign peripheral_on  = result_reg.peripheral_on;
    assign peripheral_off = result_reg.peripheral_off;
    assign send_start     = result_reg.send_start;
    assign send_stop      = result_reg.send_stop;
    assign send_address   = result_reg.send_address;
    assign address_out    = result_reg.address_out;
    assign address_read   = result_reg.address_read;
    assign send_data      = result_reg.send_data;
    assign data_out       = result_reg.data_out;
    assign dma_on         = result_reg.dma_on;
    assign dma_off        = result_reg.dma_off;
    assign done_res       = result_reg.done_res;

endmodule
